// ===== src/slid_pkg.sv =====
package slid_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned POS_W    = 4;

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // per-cycle shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

// ===== src/slid_cell.sv =====
module slid_cell (
  input  logic                                clk_i,
  input  slid_pkg::cell_ctl_t                 ctl_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] value_i,
  input  logic                                valid_i,
  input  logic                                left_lt_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] left_entry_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] right_entry_i,
  output logic                                lt_o,
  output logic                                eq_o,
  output logic                                bnd_o,
  output logic signed [slid_pkg::VALUE_W-1:0] entry_o,
  output logic signed [slid_pkg::VALUE_W-1:0] entry_next_o
);

  logic signed [slid_pkg::VALUE_W-1:0] entry_q, entry_d;

  // stored entry smaller than the broadcast value
  assign lt_o    = valid_i && (entry_q < value_i);
  assign eq_o    = valid_i && (entry_q == value_i);
  // first cell that is not smaller
  assign bnd_o   = !lt_o && left_lt_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && !lt_o) begin
      entry_d = left_lt_i ? value_i : left_entry_i;
    end else if (ctl_i.del && !lt_o) begin
      entry_d = right_entry_i;
    end
  end

  assign entry_next_o = entry_d;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== src/sorted_list_insert_delete.sv =====
// Sorted store of up to CAPACITY signed 32-bit words, kept in ascending order
// in a row of cells. An insert word goes ahead of the first stored value that
// is not smaller; a delete word removes the first stored value equal to it.
// Every accepted word gives exactly one result, shown on the result ports for
// one cycle with done_o high, in the cycle right after start was taken. The
// receiver cannot stall: results must be taken when done_o is high. All cells
// compare against the word at once and shift toward or away from the insert
// point in the same cycle, so one word is taken every cycle; busy stays low.
// An insert into a full store is dropped (status full), a delete that finds
// nothing reports not found; position then reads zero. smallest is the head
// of the list after the operation, zero when the store is empty.
module sorted_list_insert_delete (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] value_i,
  output logic                                done_o,
  output logic [slid_pkg::STATUS_W-1:0]       status_o,
  output logic [slid_pkg::COUNT_W-1:0]        count_o,
  output logic [slid_pkg::POS_W-1:0]          position_o,
  output logic signed [slid_pkg::VALUE_W-1:0] smallest_o
);

  localparam int unsigned N      = slid_pkg::CAPACITY;
  localparam int unsigned CNT_XW = (slid_pkg::CNT_W > slid_pkg::COUNT_W) ?
                                   slid_pkg::CNT_W : slid_pkg::COUNT_W;
  localparam int unsigned POS_XW = (slid_pkg::IDX_W > slid_pkg::POS_W) ?
                                   slid_pkg::IDX_W : slid_pkg::POS_W;

  // busy is never raised: every word is taken as soon as start is high
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stored entry count
  logic [slid_pkg::CNT_W-1:0] cnt_q, cnt_d;

  // cell row signals
  logic [N-1:0] lt, eq, bnd, valid;
  logic signed [slid_pkg::VALUE_W-1:0] entry [N];
  logic signed [slid_pkg::VALUE_W-1:0] entry_next [N];

  slid_pkg::cell_ctl_t ctl;

  logic full, found, is_ins, is_del;
  logic [slid_pkg::IDX_W-1:0] pos;

  assign is_ins = accept && (slid_pkg::func_e'(func_i) == slid_pkg::FUNC_INSERT);
  assign is_del = accept && (slid_pkg::func_e'(func_i) == slid_pkg::FUNC_DELETE);
  assign full   = (cnt_q == slid_pkg::CNT_W'(N));

  assign ctl.ins = is_ins && !full;
  assign ctl.del = is_del && found;

  // row of cells, each talking to its neighbors
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                                lt_left;
    logic signed [slid_pkg::VALUE_W-1:0] ent_left, ent_right;

    assign valid[i] = (slid_pkg::CNT_W'(i) < cnt_q);

    if (i == 0) begin : g_first
      assign lt_left  = 1'b1;
      assign ent_left = value_i;
    end else begin : g_mid
      assign lt_left  = lt[i-1];
      assign ent_left = entry[i-1];
    end

    if (i == N - 1) begin : g_last
      assign ent_right = entry[i];
    end else begin : g_notlast
      assign ent_right = entry[i+1];
    end

    slid_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .value_i      (value_i),
      .valid_i      (valid[i]),
      .left_lt_i    (lt_left),
      .left_entry_i (ent_left),
      .right_entry_i(ent_right),
      .lt_o         (lt[i]),
      .eq_o         (eq[i]),
      .bnd_o        (bnd[i]),
      .entry_o      (entry[i]),
      .entry_next_o (entry_next[i])
    );
  end

  // the boundary is one-hot (or absent when every cell is smaller),
  // so the index comes out of a plain or-reduction
  always_comb begin
    pos   = '0;
    found = 1'b0;
    for (int i = 0; i < N; i++) begin
      pos   = pos | ({slid_pkg::IDX_W{bnd[i]}} & slid_pkg::IDX_W'(i));
      found = found | (bnd[i] && eq[i]);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctl.ins) begin
      cnt_d = cnt_q + slid_pkg::CNT_W'(1);
    end else if (ctl.del) begin
      cnt_d = cnt_q - slid_pkg::CNT_W'(1);
    end
  end

  // result registers
  logic                                done_q;
  slid_pkg::status_e                   status_q, status_d;
  logic [slid_pkg::CNT_W-1:0]          rcnt_q;
  logic [slid_pkg::IDX_W-1:0]          rpos_q, rpos_d;
  logic signed [slid_pkg::VALUE_W-1:0] small_q, small_d;

  always_comb begin
    status_d = slid_pkg::ST_DONE;
    rpos_d   = pos;
    if (is_ins && full) begin
      status_d = slid_pkg::ST_FULL;
      rpos_d   = '0;
    end else if (is_del && !found) begin
      status_d = slid_pkg::ST_NOT_FOUND;
      rpos_d   = '0;
    end
    small_d = (cnt_d != '0) ? entry_next[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rcnt_q   <= cnt_d;
      rpos_q   <= rpos_d;
      small_q  <= small_d;
    end
  end

  logic [CNT_XW-1:0] cnt_x;
  logic [POS_XW-1:0] pos_x;
  assign cnt_x = CNT_XW'(rcnt_q);
  assign pos_x = POS_XW'(rpos_q);

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign count_o    = cnt_x[slid_pkg::COUNT_W-1:0];
  assign position_o = pos_x[slid_pkg::POS_W-1:0];
  assign smallest_o = small_q;

  // at most one insert point in the row
  a_bnd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bnd))
    else $error("more than one boundary cell");

  // count stays within capacity
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= slid_pkg::CNT_W'(N))
    else $error("count beyond capacity");

  // a dropped insert leaves the count alone
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_ins && full) |=> (cnt_q == $past(cnt_q)))
    else $error("count changed on full insert");

  // a found delete always shrinks the store by one
  a_del_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_del && found) |=> (cnt_q == $past(cnt_q) - slid_pkg::CNT_W'(1)))
    else $error("delete did not shrink count");

endmodule

// ===== sim/tb_sorted_list_insert_delete.sv =====
`timescale 1ns / 100ps

module tb_sorted_list_insert_delete;

  // one pending command word for the driver
  typedef struct {
    slid_pkg::func_e                      func;
    logic signed [slid_pkg::VALUE_W-1:0]  value;
    bit                                   hold_for_drain;  // wait for all results first
  } list_cmd_t;

  // what the block should report for one word
  typedef struct {
    slid_pkg::status_e                    status;
    logic [slid_pkg::COUNT_W-1:0]         count;
    logic [slid_pkg::POS_W-1:0]           position;
    logic signed [slid_pkg::VALUE_W-1:0]  smallest;
  } list_result_t;

  // clock, reset and block ports; the inputs are known from time zero
  logic                                 clk_i   = 1'b0;
  logic                                 rst_ni  = 1'b0;
  logic                                 start   = 1'b0;
  logic                                 func_i  = 1'b0;
  logic signed [slid_pkg::VALUE_W-1:0]  value_i = '0;
  logic                                 busy;
  logic                                 done_o;
  logic [slid_pkg::STATUS_W-1:0]        status_o;
  logic [slid_pkg::COUNT_W-1:0]         count_o;
  logic [slid_pkg::POS_W-1:0]           position_o;
  logic signed [slid_pkg::VALUE_W-1:0]  smallest_o;

  // stimulus and checking bookkeeping
  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];
  int           words_sent   = 0;
  int           results_seen = 0;
  int           mismatches   = 0;
  int           burst_left   = 1;
  int           gap_left     = 0;
  int           drain_pauses = 0;

  // predictor copy of the sorted store
  logic signed [slid_pkg::VALUE_W-1:0] list_vals[slid_pkg::CAPACITY];
  int           list_fill  = 0;
  int           n_inserts  = 0;
  int           n_deletes  = 0;
  int           n_dropped  = 0;
  int           n_misses   = 0;
  int           peak_fill  = 0;

  sorted_list_insert_delete dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (func_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .count_o    (count_o),
    .position_o (position_o),
    .smallest_o (smallest_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // reset held low from time zero, then released once and never again
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // apply one word to the predictor store and return the expected result
  function automatic list_result_t apply_list_op(slid_pkg::func_e op,
                                                 logic signed [slid_pkg::VALUE_W-1:0] val);
    list_result_t r;
    int           slot;
    int           k;
    r.status = slid_pkg::ST_DONE;
    slot     = 0;
    if (op == slid_pkg::FUNC_INSERT) begin
      n_inserts++;
      if (list_fill >= slid_pkg::CAPACITY) begin
        // full store: insert dropped, nothing moves
        r.status = slid_pkg::ST_FULL;
        n_dropped++;
      end else begin
        // goes after all strictly smaller values, ahead of its equals
        while (slot < list_fill && list_vals[slot] < val) slot++;
        for (k = list_fill; k > slot; k--) list_vals[k] = list_vals[k-1];
        list_vals[slot] = val;
        list_fill++;
        if (list_fill > peak_fill) peak_fill = list_fill;
      end
    end else begin
      n_deletes++;
      while (slot < list_fill && list_vals[slot] != val) slot++;
      if (slot >= list_fill) begin
        // no equal entry, empty store included
        r.status = slid_pkg::ST_NOT_FOUND;
        slot     = 0;
        n_misses++;
      end else begin
        for (k = slot; k + 1 < list_fill; k++) list_vals[k] = list_vals[k+1];
        list_fill--;
      end
    end
    r.count    = list_fill[slid_pkg::COUNT_W-1:0];
    r.position = slot[slid_pkg::POS_W-1:0];
    r.smallest = (list_fill > 0) ? list_vals[0] : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [slid_pkg::VALUE_W-1:0] got,
                                 logic [slid_pkg::VALUE_W-1:0] want);
    mismatches++;
    // keep the log short when things go badly wrong
    if (mismatches <= 40)
      $display("mismatch at result %0d: %s got %0h want %0h",
               results_seen, what, got, want);
  endtask

  task automatic push_cmd(slid_pkg::func_e f, logic signed [slid_pkg::VALUE_W-1:0] v,
                          bit hold);
    list_cmd_t c;
    c.func           = f;
    c.value          = v;
    c.hold_for_drain = hold;
    pending_cmds.push_back(c);
  endtask

  // driver: a word is taken at an edge where start is high and busy is low; the next
  // word goes out at that same edge unless a gap or a drain wait is due or none is pending
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      func_i  <= 1'b0;
      value_i <= '0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_list_op(slid_pkg::func_e'(func_i), value_i));
        words_sent++;
      end
      if (start && busy) begin
        // word not taken yet, hold it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (pending_cmds[0].hold_for_drain && words_sent != results_seen) begin
        // pause until every result in flight has come back
        start <= 1'b0;
      end else begin
        if (pending_cmds[0].hold_for_drain) drain_pauses++;
        start   <= 1'b1;
        func_i  <= pending_cmds[0].func;
        value_i <= pending_cmds[0].value;
        pending_cmds.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          // mostly short bursts, now and then a long stretch with no idling
          burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // monitor: every done_o cycle is one result, checked against the oldest expectation
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, status",
                        slid_pkg::VALUE_W'(status_o), '0);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", slid_pkg::VALUE_W'(status_o),
                          slid_pkg::VALUE_W'(want.status));
        if (count_o !== want.count)
          report_mismatch("count", slid_pkg::VALUE_W'(count_o),
                          slid_pkg::VALUE_W'(want.count));
        if (position_o !== want.position)
          report_mismatch("position", slid_pkg::VALUE_W'(position_o),
                          slid_pkg::VALUE_W'(want.position));
        if (smallest_o !== want.smallest)
          report_mismatch("smallest", smallest_o, want.smallest);
      end
      results_seen <= results_seen + 1;
    end
  end

  // stimulus: directed corners first, then random phases over a small value pool
  initial begin
    logic signed [slid_pkg::VALUE_W-1:0] pool[8];
    int                                  k;
    int                                  ins_pct;
    int                                  random_words;
    bit                                  hold;

    // delete on an empty store
    push_cmd(slid_pkg::FUNC_DELETE, 32'sd5, 1'b0);
    // extremes, zero, duplicate and minus one
    push_cmd(slid_pkg::FUNC_INSERT, 32'sh7fff_ffff, 1'b0);
    push_cmd(slid_pkg::FUNC_INSERT, 32'sh8000_0000, 1'b0);
    push_cmd(slid_pkg::FUNC_INSERT, 32'sd0, 1'b0);
    push_cmd(slid_pkg::FUNC_INSERT, 32'sd0, 1'b0);
    push_cmd(slid_pkg::FUNC_INSERT, -32'sd1, 1'b0);
    // delete one of a pair of equals, then a value that is absent
    push_cmd(slid_pkg::FUNC_DELETE, 32'sd0, 1'b0);
    push_cmd(slid_pkg::FUNC_DELETE, 32'sd12345, 1'b0);
    // fill up to capacity, with some equal values mixed in
    for (k = 0; k < slid_pkg::CAPACITY - 4; k++)
      push_cmd(slid_pkg::FUNC_INSERT, (k % 3 == 0) ? 32'sd7 : (k * 1000 - 5000), 1'b0);
    // insert into a full store, then delete at the tail and at the head
    push_cmd(slid_pkg::FUNC_INSERT, 32'sd42, 1'b0);
    push_cmd(slid_pkg::FUNC_DELETE, 32'sh7fff_ffff, 1'b0);
    push_cmd(slid_pkg::FUNC_DELETE, 32'sh8000_0000, 1'b0);

    // random phases; the insert mix swings between draining and filling the store
    random_words = 0;
    hold         = 1'b1;
    while (random_words < 600) begin
      for (k = 0; k < 8; k++) begin
        case ($urandom_range(3))
          0: pool[k] = $urandom;
          1: pool[k] = int'($urandom_range(16)) - 8;
          2: pool[k] = ($urandom_range(1) == 1) ? 32'sh7fff_ffff - $urandom_range(2)
                                                 : 32'sh8000_0000 + $urandom_range(2);
          default: pool[k] = ($urandom_range(1) == 1) ? -32'sd1 : 32'sd0;
        endcase
      end
      case ($urandom_range(3))
        0: ins_pct = 15;
        1: ins_pct = 50;
        2: ins_pct = 85;
        default: ins_pct = 100;
      endcase
      for (k = 0; k < 40; k++) begin
        push_cmd(($urandom_range(99) < ins_pct) ? slid_pkg::FUNC_INSERT
                                                : slid_pkg::FUNC_DELETE,
                 ($urandom_range(9) < 7) ? pool[$urandom_range(7)] : $urandom, hold);
        hold = 1'b0;
        random_words++;
      end
      // some phases begin only once the block has gone quiet
      hold = ($urandom_range(2) == 0);
    end

    // wait for the driver to run dry and all results to arrive, then settle
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered, count",
                      slid_pkg::VALUE_W'(expected_results.size()), '0);

    $display("covered %0d words: %0d inserts (%0d dropped on a full store), %0d deletes",
             words_sent, n_inserts, n_dropped, n_deletes);
    $display("%0d delete misses, peak fill %0d of %0d, %0d drain pauses, %0d mismatches",
             n_misses, peak_fill, slid_pkg::CAPACITY, drain_pauses, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #2_000_000;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
